// ===== src/bae_pkg.sv =====
// ----------------------------------------------------------------------------
// bae_pkg
// Shared widths, defaults and status codes of the block average error
// estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package bae_pkg;

  localparam int unsigned MAX_SAMPLES_DEF = 4096;
  localparam int unsigned MAX_BLOCKS_DEF  = 256;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned BC_W     = 9;    // block_count register
  localparam int unsigned SKIP_W   = 16;   // skip_count register
  localparam int unsigned SEEN_W   = 17;   // saturating run length
  localparam int unsigned PER_W    = 17;   // samples per block
  localparam int unsigned BI_W     = 10;   // block counter, holds up to 1023
  localparam int unsigned STATUS_W = 3;

  localparam int unsigned DIV_NW = 96;     // divider numerator / quotient
  localparam int unsigned DIV_DW = 64;     // divider denominator
  localparam int unsigned MUL_W  = 33;     // shared multiplier operands

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_COUNT  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_FEW   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY_BLK = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNDER_TWO = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ZERO_VAR  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd5;

endpackage

`default_nettype wire

// ===== src/block_average_error_estimator_unit.sv =====
// ----------------------------------------------------------------------------
// block_average_error_estimator_unit
// Blocking-method estimator of mean, standard error and autocorrelation time.
// ----------------------------------------------------------------------------
// Usage:
//  - Input: a sample transaction is taken when start_i is high and busy_o low.
//    While collecting, one sample per cycle is taken; the first skip_count
//    samples of a run are dropped, the rest are written to the sample RAM.
//  - The sample flagged is_last_i starts the compute phase; busy_o stays high
//    until the result is out.
//  - Compute: a divide for the block size, one RAM read per used sample
//    (states S_RD, S_SQ, S_ACC, through the RAM read and the shared
//    multiplier), a divide per block mean, divides for the mean and mean
//    square, a pass over the block means for the deviation sum, divides
//    for the block variance and error radicand, a square root (skipped,
//    error saturated, if the radicand exceeds 48 bits) and a tau divide
//    (skipped at zero variance). Special cases are reported from S_CHECK.
//  - Result: result_valid_o pulses for one cycle with all fields; the
//    receiver cannot stall, so the result transaction is always taken.
//  - Config: cfg_ready_o is always high; writes go to block_count (index 0)
//    or skip_count (index 1) and are meant only for while the block is idle.
//  - Reset clears the run counters and loads block_count 10, skip_count 0.
//    The RAMs are not cleared; only entries written in the current run are
//    read.
// ----------------------------------------------------------------------------
`default_nettype none

module block_average_error_estimator_unit #(
  parameter int unsigned MAX_SAMPLES = bae_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned MAX_BLOCKS  = bae_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // sample channel
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic signed [bae_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic                              is_last_i,
  // configuration channel
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [bae_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [bae_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // result channel
  output logic                                   result_valid_o,
  output logic [bae_pkg::STATUS_W-1:0]           status_o,
  output logic signed [31:0]                     mean_o,
  output logic [31:0]                            std_error_o,
  output logic [31:0]                            autocorr_time_o,
  output logic [bae_pkg::BC_W-1:0]               blocks_used_o
);
  import bae_pkg::*;

  localparam int unsigned SAW = $clog2(MAX_SAMPLES);       // sample RAM address
  localparam int unsigned SCW = $clog2(MAX_SAMPLES + 1);   // stored count
  localparam int unsigned BAW = $clog2(MAX_BLOCKS);        // block RAM address

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_DIVPER, S_CNT, S_RD, S_SQ, S_ACC, S_BDIV,
    S_MDIV, S_S2DIV, S_DRD, S_DSQ, S_DACC, S_VBDIV, S_QDIV, S_SQRT,
    S_TAU0, S_TAU1, S_TAU2, S_TDIV
  } state_e;

  state_e state_q;

  // configuration
  logic [BC_W-1:0]   block_count_q;
  logic [SKIP_W-1:0] skip_count_q;

  // run state
  logic [SEEN_W-1:0] seen_q;
  logic [SCW-1:0]    stored_q;
  logic              ovf_q;

  // compute state
  logic [BC_W-1:0]          nb_q;
  logic [PER_W-1:0]         per_q, j_q;
  logic [SEEN_W-1:0]        count_q;
  logic [SCW-1:0]           k_q;
  logic [BI_W-1:0]          bi_q;
  logic signed [47:0]       bsum_q;
  logic signed [55:0]       sum_q;
  logic [63:0]              sq_q, dev_q, var_q, vb_q;
  logic [48:0]              prod_q;
  logic signed [31:0]       mean_q;

  // result registers
  logic                     res_valid_q;
  logic [STATUS_W-1:0]      status_q;
  logic signed [31:0]       mean_out_q;
  logic [31:0]              err_q, tau_q;

  // memories
  logic [SAMPLE_W-1:0] smem [MAX_SAMPLES];
  logic [SAMPLE_W-1:0] bmem [MAX_BLOCKS];
  logic [SAMPLE_W-1:0] srd_q, brd_q;
  logic                smem_we, bmem_we;
  logic [SAMPLE_W-1:0] bmem_wdata;

  // shared units
  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [2*MUL_W-1:0]  mul_q;
  logic                div_start, div_done;
  logic [DIV_NW-1:0]   div_num, div_quo;
  logic [DIV_DW-1:0]   div_den;
  logic                sqrt_start, sqrt_done;
  logic [31:0]         sqrt_root;

  logic                accept, take_sample;
  logic [BC_W-1:0]     nb_clamped;
  logic signed [31:0]  x;
  logic [31:0]         x_mag;
  logic signed [32:0]  dev;
  logic [32:0]         dev_mag;
  logic [31:0]         mean_mag;
  logic [49:0]         mean_sq2;
  logic [31:0]         bm_round, mean_round;
  logic [63:0]         s2;

  assign accept      = start_i && !busy_o;
  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign take_sample = accept && (seen_q >= SEEN_W'(skip_count_q));
  assign smem_we     = take_sample && (32'(stored_q) < MAX_SAMPLES);

  assign nb_clamped = (32'(block_count_q) > MAX_BLOCKS) ? BC_W'(MAX_BLOCKS)
                                                         : block_count_q;

  assign x        = $signed(srd_q);
  assign x_mag    = x[31] ? 32'(-x) : 32'(x);
  assign dev      = 33'($signed(brd_q)) - 33'(mean_q);
  assign dev_mag  = dev[32] ? 33'(-dev) : 33'(dev);
  assign mean_mag = mean_q[31] ? 32'(-mean_q) : 32'(mean_q);
  assign mean_sq2 = mul_q[65:16];
  assign s2       = div_quo[63:0];

  // Round-half-away magnitude quotient, clamped to signed 32 bits.
  function automatic logic [31:0] clamp_round(input logic [DIV_NW-1:0] q,
                                              input logic neg);
    logic [31:0] r;
    if (neg) begin
      r = (q > DIV_NW'(33'h080000000)) ? 32'h80000000 : 32'(-q[31:0]);
    end else begin
      r = (q > DIV_NW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : q[31:0];
    end
    return r;
  endfunction

  assign bm_round   = clamp_round(div_quo, bsum_q < 0);
  assign mean_round = clamp_round(div_quo, sum_q < 0);
  assign bmem_we    = (state_q == S_BDIV) && div_done;
  assign bmem_wdata = bm_round;

  // sample RAM
  always_ff @(posedge clk_i) begin
    if (smem_we) begin
      smem[stored_q[SAW-1:0]] <= sample_i;
    end
    srd_q <= smem[k_q[SAW-1:0]];
  end

  // block mean RAM
  always_ff @(posedge clk_i) begin
    if (bmem_we) begin
      bmem[bi_q[BAW-1:0]] <= bmem_wdata;
    end
    brd_q <= bmem[bi_q[BAW-1:0]];
  end

  // shared multiplier, registered
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_DIVPER: begin
        mul_a = MUL_W'(div_quo[PER_W-1:0]);
        mul_b = MUL_W'(nb_q);
      end
      S_SQ: begin
        mul_a = MUL_W'(x_mag);
        mul_b = MUL_W'(x_mag);
      end
      S_S2DIV: begin
        mul_a = MUL_W'(mean_mag);
        mul_b = MUL_W'(mean_mag);
      end
      S_DSQ: begin
        mul_a = dev_mag;
        mul_b = dev_mag;
      end
      S_VBDIV: begin
        mul_a = MUL_W'(nb_q - 1'b1);
        mul_b = MUL_W'(nb_q);
      end
      S_TAU0: begin
        mul_a = MUL_W'(per_q);
        mul_b = MUL_W'(vb_q[31:0]);
      end
      S_TAU1: begin
        mul_a = MUL_W'(per_q);
        mul_b = MUL_W'(vb_q[63:32]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  // divider operand selection
  always_comb begin
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    sqrt_start = 1'b0;
    case (state_q)
      S_CHECK: begin
        div_num = DIV_NW'(stored_q);
        div_den = DIV_DW'(nb_clamped);
      end
      S_ACC: begin
        div_num = DIV_NW'((bsum_q < 0 ? 48'(-bsum_q) : 48'(bsum_q)))
                + DIV_NW'(per_q >> 1);
        div_den = DIV_DW'(per_q);
        div_start = (j_q == per_q);
      end
      S_BDIV: begin
        div_num = DIV_NW'((sum_q < 0 ? 56'(-sum_q) : 56'(sum_q)))
                + DIV_NW'(count_q >> 1);
        div_den = DIV_DW'(count_q);
        div_start = div_done && (bi_q == BI_W'(nb_q) - 1'b1);
      end
      S_MDIV: begin
        div_num = DIV_NW'(sq_q);
        div_den = DIV_DW'(count_q);
        div_start = div_done;
      end
      S_DACC: begin
        div_num = DIV_NW'(dev_q + (mul_q[65:16]));
        div_den = DIV_DW'(nb_q - 1'b1);
        div_start = (bi_q == BI_W'(nb_q));
      end
      S_VBDIV: begin
        div_num = DIV_NW'(dev_q);
        div_den = DIV_DW'(mul_q[19:0]);
        div_start = div_done;
      end
      S_QDIV: begin
        sqrt_start = div_done && (div_quo[DIV_NW-1:48] == '0);
      end
      S_TAU2: begin
        div_num = (DIV_NW'(prod_q) + (DIV_NW'(mul_q) << 32)) << 15;
        div_den = var_q;
        div_start = 1'b1;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
    if (state_q == S_CHECK) begin
      div_start = !((seen_q <= SEEN_W'(skip_count_q)) || ovf_q || (nb_clamped < 2)
                    || (32'(stored_q) < 32'(nb_clamped)));
    end
  end

  bae_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  bae_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   ({div_quo[47:0], 16'h0000}),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= BC_W'(10);
      skip_count_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_BLOCK_COUNT: block_count_q <= cfg_data_i[BC_W-1:0];
        REG_SKIP_COUNT:  skip_count_q  <= cfg_data_i;
        default:         skip_count_q  <= skip_count_q;
      endcase
    end
  end

  // sequencer with run state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seen_q      <= '0;
      stored_q    <= '0;
      ovf_q       <= 1'b0;
      res_valid_q <= 1'b0;
      status_q    <= ST_OK;
      mean_out_q  <= '0;
      err_q       <= '0;
      tau_q       <= '0;
      nb_q        <= '0;
      per_q       <= '0;
      j_q         <= '0;
      count_q     <= '0;
      k_q         <= '0;
      bi_q        <= '0;
      bsum_q      <= '0;
      sum_q       <= '0;
      sq_q        <= '0;
      dev_q       <= '0;
      var_q       <= '0;
      vb_q        <= '0;
      prod_q      <= '0;
      mean_q      <= '0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (take_sample) begin
              if (smem_we) stored_q <= stored_q + 1'b1;
              else         ovf_q    <= 1'b1;
            end
            if (seen_q != '1) seen_q <= seen_q + 1'b1;
            if (is_last_i) state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          nb_q       <= nb_clamped;
          mean_out_q <= '0;
          err_q      <= '0;
          tau_q      <= '0;
          status_q   <= ST_OK;
          if (seen_q <= SEEN_W'(skip_count_q)) begin
            status_q <= ST_TOO_FEW;
            state_q  <= S_IDLE;
          end else if (ovf_q) begin
            status_q <= ST_OVERFLOW;
            state_q  <= S_IDLE;
          end else if (nb_clamped < 2) begin
            status_q <= ST_UNDER_TWO;
            state_q  <= S_IDLE;
          end else if (32'(stored_q) < 32'(nb_clamped)) begin
            status_q <= ST_EMPTY_BLK;
            state_q  <= S_IDLE;
          end else begin
            state_q <= S_DIVPER;
          end
          if (!div_start) begin
            // special case: report now and end the run
            res_valid_q <= 1'b1;
            seen_q      <= '0;
            stored_q    <= '0;
            ovf_q       <= 1'b0;
          end
        end
        S_DIVPER: begin
          if (div_done) begin
            per_q   <= div_quo[PER_W-1:0];
            state_q <= S_CNT;
          end
        end
        S_CNT: begin
          count_q <= mul_q[SEEN_W-1:0];
          k_q     <= SCW'(32'(stored_q) - 32'(mul_q[SEEN_W-1:0]));
          bi_q    <= '0;
          j_q     <= '0;
          bsum_q  <= '0;
          sum_q   <= '0;
          sq_q    <= '0;
          state_q <= S_RD;
        end
        S_RD: begin
          state_q <= S_SQ;
        end
        S_SQ: begin
          bsum_q  <= bsum_q + 48'(x);
          sum_q   <= sum_q + 56'(x);
          k_q     <= k_q + 1'b1;
          j_q     <= j_q + 1'b1;
          state_q <= S_ACC;
        end
        S_ACC: begin
          sq_q    <= sq_q + 64'(mul_q[65:16]);
          state_q <= (j_q == per_q) ? S_BDIV : S_RD;
        end
        S_BDIV: begin
          if (div_done) begin
            bi_q   <= bi_q + 1'b1;
            j_q    <= '0;
            bsum_q <= '0;
            state_q <= (bi_q == BI_W'(nb_q) - 1'b1) ? S_MDIV : S_RD;
          end
        end
        S_MDIV: begin
          if (div_done) begin
            mean_q  <= $signed(mean_round);
            state_q <= S_S2DIV;
          end
        end
        S_S2DIV: begin
          if (div_done) begin
            var_q   <= (s2 > 64'(mean_sq2)) ? s2 - 64'(mean_sq2) : '0;
            bi_q    <= '0;
            dev_q   <= '0;
            state_q <= S_DRD;
          end
        end
        S_DRD: begin
          state_q <= S_DSQ;
        end
        S_DSQ: begin
          bi_q    <= bi_q + 1'b1;
          state_q <= S_DACC;
        end
        S_DACC: begin
          dev_q   <= dev_q + 64'(mul_q[65:16]);
          state_q <= (bi_q == BI_W'(nb_q)) ? S_VBDIV : S_DRD;
        end
        S_VBDIV: begin
          if (div_done) begin
            vb_q    <= div_quo[63:0];
            state_q <= S_QDIV;
          end
        end
        S_QDIV: begin
          if (div_done) begin
            if (div_quo[DIV_NW-1:48] != '0) begin
              err_q   <= '1;
              state_q <= S_TAU0;
            end else begin
              state_q <= S_SQRT;
            end
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            err_q   <= sqrt_root;
            state_q <= S_TAU0;
          end
        end
        S_TAU0: begin
          mean_out_q <= mean_q;
          if (var_q == '0) begin
            // zero variance: mean and error stand, tau is zero
            status_q    <= ST_ZERO_VAR;
            tau_q       <= '0;
            res_valid_q <= 1'b1;
            seen_q      <= '0;
            stored_q    <= '0;
            ovf_q       <= 1'b0;
            state_q     <= S_IDLE;
          end else begin
            state_q <= S_TAU1;
          end
        end
        S_TAU1: begin
          prod_q  <= mul_q[48:0];
          state_q <= S_TAU2;
        end
        S_TAU2: begin
          state_q <= S_TDIV;
        end
        S_TDIV: begin
          if (div_done) begin
            tau_q       <= (div_quo[DIV_NW-1:32] != '0) ? '1 : div_quo[31:0];
            res_valid_q <= 1'b1;
            seen_q      <= '0;
            stored_q    <= '0;
            ovf_q       <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign result_valid_o  = res_valid_q;
  assign status_o        = status_q;
  assign mean_o          = mean_out_q;
  assign std_error_o     = err_q;
  assign autocorr_time_o = tau_q;
  assign blocks_used_o   = nb_q;

endmodule

`default_nettype wire

// ===== src/bae_div.sv =====
// ----------------------------------------------------------------------------
// bae_div
// Restoring long divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bae_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [bae_pkg::DIV_NW-1:0]  num_i,
  input  wire logic [bae_pkg::DIV_DW-1:0]  den_i,
  output logic                             done_o,
  output logic [bae_pkg::DIV_NW-1:0]       quo_o
);
  import bae_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_NW);

  logic [DIV_DW-1:0] rem_q, den_q;
  logic [DIV_NW-1:0] quo_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              run_q, done_q;

  logic [DIV_DW:0]   shifted;
  logic              fits;

  assign shifted = {rem_q, quo_q[DIV_NW-1]};
  assign fits    = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_NW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      quo_q <= num_i;
    end else if (run_q) begin
      rem_q <= fits ? DIV_DW'(shifted - {1'b0, den_q}) : shifted[DIV_DW-1:0];
      quo_q <= {quo_q[DIV_NW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ===== src/bae_sqrt.sv =====
// ----------------------------------------------------------------------------
// bae_sqrt
// Integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bae_sqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] rad_i,
  output logic             done_o,
  output logic [31:0]      root_o
);
  import bae_pkg::*;

  logic [63:0] rad_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [4:0]  cnt_q;
  logic        run_q, done_q;

  logic [35:0] trial_rem, trial;
  logic        fits;

  assign trial_rem = {rem_q, rad_q[63:62]};
  assign trial     = {2'b00, root_q, 2'b01};
  assign fits      = trial_rem >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 5'd31) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      rad_q  <= {rad_q[61:0], 2'b00};
      rem_q  <= 34'(fits ? trial_rem - trial : trial_rem);
      root_q <= {root_q[30:0], fits};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire
